// ===== rtl/core/order_book_table_top_macros.svh =====
// Assertion macros shared by the order table modules.
`ifndef ORDER_BOOK_TABLE_TOP_MACROS_SVH
`define ORDER_BOOK_TABLE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define OBT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("order table assertion failed");
`define OBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("order table assertion failed");
`else
`define OBT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define OBT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/obt_pkg.sv =====
package obt_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_MODIFY = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_GET    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_INVALID   = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t        op;
		logic [31:0] order_id;
		logic [31:0] price;
		logic [30:0] quantity;
		logic        is_buy;
		logic        skip;
		status_t     pre_status;
	} req_t;

endpackage

// ===== rtl/core/obt_front.sv =====
module obt_front (
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [1:0]    cmd,
	input  logic [31:0]   order_id,
	input  logic [31:0]   price,
	input  logic [30:0]   quantity,
	input  logic          is_buy,
	input  logic          q_full,
	output logic          push,
	output obt_pkg::req_t req
);
	import obt_pkg::*;

	logic bad_params;

	assign in_stall = q_full;
	assign push = in_valid && !q_full;
	assign bad_params = (order_id == '0) || (price == '0) || (quantity == '0);

	always_comb begin
		req.op = cmd_t'(cmd);
		req.order_id = order_id;
		req.price = price;
		req.quantity = quantity;
		req.is_buy = is_buy;
		req.skip = 1'b0;
		req.pre_status = ST_OK;
		unique case (cmd_t'(cmd))
			CMD_ADD, CMD_MODIFY: begin
				if (bad_params) begin
					req.skip = 1'b1;
					req.pre_status = ST_INVALID;
				end
			end
			CMD_DELETE: begin
				if (order_id == '0) begin
					req.skip = 1'b1;
					req.pre_status = ST_INVALID;
				end
			end
			CMD_GET: begin
				if (order_id == '0) begin
					req.skip = 1'b1;
					req.pre_status = ST_NOT_FOUND;
				end
			end
			default: begin
				req.skip = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/core/obt_queue.sv =====
`include "order_book_table_top_macros.svh"

module obt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  obt_pkg::req_t push_req,
	input  logic          pop,
	output logic          full,
	output logic          not_empty,
	output obt_pkg::req_t head
);
	import obt_pkg::*;

	req_t                  store_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;

	assign full = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`OBT_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= (QUEUE_AW+1)'(QUEUE_DEPTH))
	`OBT_ASSERT_IMPL(a_no_push_full, clk, arst_n, push, !full)
	`OBT_ASSERT_IMPL(a_no_pop_empty, clk, arst_n, pop, not_empty)

endmodule

// ===== rtl/core/obt_back.sv =====
`include "order_book_table_top_macros.svh"

module obt_back #(
	parameter int DEPTH = obt_pkg::TABLE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  obt_pkg::req_t q_req,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [1:0]    status,
	output logic [31:0]   entry_price,
	output logic [30:0]   entry_quantity,
	output logic          entry_is_buy
);
	import obt_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	logic [31:0] mem_id    [DEPTH];
	logic [31:0] mem_price [DEPTH];
	logic [30:0] mem_qty   [DEPTH];
	logic        mem_side  [DEPTH];
	logic        mem_vld   [DEPTH];

	state_t         state_q;
	logic [CW-1:0]  addr_q;
	req_t           cur_q;
	logic           hit_q;
	logic [AW-1:0]  hit_idx_q;
	logic           free_found_q;
	logic [AW-1:0]  free_idx_q;
	logic [31:0]    cap_price_q;
	logic [30:0]    cap_qty_q;
	logic           cap_side_q;
	logic           out_valid_q;
	status_t        status_q;
	logic [31:0]    entry_price_q;
	logic [30:0]    entry_quantity_q;
	logic           entry_is_buy_q;

	logic           live_s1;
	logic [AW-1:0]  idx_s1;
	logic [31:0]    rd_id_s1;
	logic           rd_vld_s1;
	logic [31:0]    rd_price_s1;
	logic [30:0]    rd_qty_s1;
	logic           rd_side_s1;

	logic           fin_go;
	logic           wr_all;
	logic           wr_pq;
	logic           vld_we;
	logic           vld_val;
	logic [AW-1:0]  wr_idx;
	logic [AW-1:0]  vld_idx;
	status_t        res_status;
	logic [31:0]    res_price;
	logic [30:0]    res_qty;
	logic           res_side;
	logic           issuing;

	assign fin_go = (state_q == S_FINISH) && (!out_valid_q || !out_stall);
	assign pop = (state_q == S_IDLE) && q_valid;
	assign issuing = (state_q == S_SCAN) && (addr_q != CW'(DEPTH));

	always_comb begin
		res_status = ST_OK;
		res_price = '0;
		res_qty = '0;
		res_side = 1'b0;
		wr_all = 1'b0;
		wr_pq = 1'b0;
		wr_idx = hit_idx_q;
		vld_we = 1'b0;
		vld_val = 1'b0;
		vld_idx = hit_idx_q;
		if (cur_q.skip) begin
			res_status = cur_q.pre_status;
		end else begin
			unique case (cur_q.op)
				CMD_ADD: begin
					if (hit_q) begin
						wr_all = fin_go;
					end else if (free_found_q) begin
						wr_all = fin_go;
						wr_idx = free_idx_q;
					end else begin
						res_status = ST_FULL;
					end
				end
				CMD_MODIFY: begin
					if (hit_q) begin
						wr_pq = fin_go;
					end else begin
						res_status = ST_NOT_FOUND;
					end
				end
				CMD_DELETE: begin
					if (hit_q) begin
						vld_we = fin_go;
					end else begin
						res_status = ST_NOT_FOUND;
					end
				end
				CMD_GET: begin
					if (hit_q) begin
						res_price = cap_price_q;
						res_qty = cap_qty_q;
						res_side = cap_side_q;
					end else begin
						res_status = ST_NOT_FOUND;
					end
				end
				default: begin
					res_status = ST_NOT_FOUND;
				end
			endcase
		end
		if (wr_all) begin
			vld_we = 1'b1;
			vld_val = 1'b1;
			vld_idx = wr_idx;
		end
		if (state_q == S_CLEAR) begin
			vld_we = 1'b1;
			vld_val = 1'b0;
			vld_idx = addr_q[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_all) begin
			mem_id[wr_idx] <= cur_q.order_id;
			mem_side[wr_idx] <= cur_q.is_buy;
		end
		if (wr_all || wr_pq) begin
			mem_price[wr_idx] <= cur_q.price;
			mem_qty[wr_idx] <= cur_q.quantity;
		end
		if (vld_we) begin
			mem_vld[vld_idx] <= vld_val;
		end
		rd_id_s1 <= mem_id[addr_q[AW-1:0]];
		rd_vld_s1 <= mem_vld[addr_q[AW-1:0]];
		rd_price_s1 <= mem_price[addr_q[AW-1:0]];
		rd_qty_s1 <= mem_qty[addr_q[AW-1:0]];
		rd_side_s1 <= mem_side[addr_q[AW-1:0]];
		idx_s1 <= addr_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			addr_q <= '0;
			cur_q <= '0;
			hit_q <= 1'b0;
			hit_idx_q <= '0;
			free_found_q <= 1'b0;
			free_idx_q <= '0;
			cap_price_q <= '0;
			cap_qty_q <= '0;
			cap_side_q <= 1'b0;
			live_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			status_q <= ST_OK;
			entry_price_q <= '0;
			entry_quantity_q <= '0;
			entry_is_buy_q <= 1'b0;
		end else begin
			live_s1 <= issuing;
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (addr_q == CW'(DEPTH - 1)) begin
						addr_q <= '0;
						state_q <= S_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						cur_q <= q_req;
						hit_q <= 1'b0;
						free_found_q <= 1'b0;
						addr_q <= '0;
						state_q <= q_req.skip ? S_FINISH : S_SCAN;
					end
				end
				S_SCAN: begin
					if (issuing) begin
						addr_q <= addr_q + 1'b1;
					end
					if (live_s1) begin
						if (rd_vld_s1 && (rd_id_s1 == cur_q.order_id) && !hit_q) begin
							hit_q <= 1'b1;
							hit_idx_q <= idx_s1;
							cap_price_q <= rd_price_s1;
							cap_qty_q <= rd_qty_s1;
							cap_side_q <= rd_side_s1;
						end
						if (!rd_vld_s1 && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q <= idx_s1;
						end
					end
					if (!issuing && !live_s1) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (fin_go) begin
						status_q <= res_status;
						entry_price_q <= res_price;
						entry_quantity_q <= res_qty;
						entry_is_buy_q <= res_side;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign entry_price = entry_price_q;
	assign entry_quantity = entry_quantity_q;
	assign entry_is_buy = entry_is_buy_q;

	`OBT_ASSERT_IMPL(a_scan_bound, clk, arst_n, 1'b1, addr_q <= CW'(DEPTH))
	`OBT_ASSERT_IMPL(a_clear_no_pop, clk, arst_n, state_q == S_CLEAR, !pop)
	`OBT_ASSERT_NEXT(a_hit_holds, clk, arst_n, state_q == S_SCAN && hit_q, hit_q)
	`OBT_ASSERT_IMPL(a_fields_zero, clk, arst_n, out_valid_q && status_q != ST_OK, entry_price_q == '0 && entry_quantity_q == '0 && !entry_is_buy_q)

endmodule

// ===== rtl/core/order_book_table_top.sv =====
// Table of resting orders keyed by order id, holding up to TABLE_DEPTH entries of price, quantity
// and side, with add, modify, delete and get requests and one result per request. Each request
// that passes the parameter checks scans every slot of the slot memory, one slot read per cycle,
// before its result is registered, and the next request leaves the queue only after that; a
// request rejected by the checks skips the scan and goes straight to the finish state. A finished
// result waits in the scanner while an earlier result is still held by the receiver. A two-entry
// queue takes new requests while the scanner works, and the result register holds a finished
// result while the next request runs. After reset a clearing pass over every slot empties the
// table; requests are queued during that pass but none completes before it ends.
module order_book_table_top #(
	parameter int TABLE_DEPTH = obt_pkg::TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [31:0] order_id,
	input  logic [31:0] price,
	input  logic [30:0] quantity,
	input  logic        is_buy,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] entry_price,
	output logic [30:0] entry_quantity,
	output logic        entry_is_buy
);
	import obt_pkg::*;

	logic q_full;
	logic q_not_empty;
	logic push;
	logic pop;
	req_t push_req;
	req_t head_req;

	obt_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.order_id (order_id),
		.price    (price),
		.quantity (quantity),
		.is_buy   (is_buy),
		.q_full   (q_full),
		.push     (push),
		.req      (push_req)
	);

	obt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_req  (push_req),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head_req)
	);

	obt_back #(
		.DEPTH (TABLE_DEPTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_not_empty),
		.q_req          (head_req),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.entry_price    (entry_price),
		.entry_quantity (entry_quantity),
		.entry_is_buy   (entry_is_buy)
	);

endmodule

// ===== verif/order_book_table_top_test.sv =====
module order_book_table_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import obt_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam int POOL_SIZE = 96;
	localparam int RANDOM_REQS = 1700;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT = 4000;

	typedef struct packed {
		status_t     status;
		logic [31:0] px;
		logic [30:0] qty;
		logic        side;
	} book_result_t;

	typedef struct {
		cmd_t         op;
		logic [31:0]  id;
		logic [31:0]  px;
		logic [30:0]  qty;
		logic         side;
		bit           fixed;
		book_result_t want;
	} order_req_t;

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_CHURN, MIX_NOISE} traffic_t;
	typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd = CMD_GET;
	logic [31:0] order_id = '0;
	logic [31:0] price = '0;
	logic [30:0] quantity = '0;
	logic        is_buy = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [31:0] entry_price;
	logic [30:0] entry_quantity;
	logic        entry_is_buy;

	bit           req_fixed = 1'b0;
	book_result_t req_want = '0;

	logic        slot_used [DEPTH];
	logic [31:0] slot_key [DEPTH];
	logic [31:0] slot_px [DEPTH];
	logic [30:0] slot_qty [DEPTH];
	logic        slot_side [DEPTH];

	book_result_t book_results_due [$];
	logic [31:0]  id_pool [POOL_SIZE];
	order_req_t   directed_rows [25];
	int           pool_walk = 0;
	int           burst_left = 0;
	int           reqs_taken = 0;
	int           idle_cycles = 0;
	int           errors = 0;

	order_book_table_top #(.TABLE_DEPTH(DEPTH)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.order_id(order_id),
		.price(price),
		.quantity(quantity),
		.is_buy(is_buy),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.entry_price(entry_price),
		.entry_quantity(entry_quantity),
		.entry_is_buy(entry_is_buy)
	);

	always #5 clk = ~clk;

	function automatic book_result_t apply_order_cmd(cmd_t op, logic [31:0] id,
		logic [31:0] px, logic [30:0] qty, logic side);
		book_result_t res;
		int hit;
		int slot;
		res = '0;
		hit = -1;
		slot = -1;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (slot_used[i] && slot_key[i] == id)
				hit = i;
			if (!slot_used[i])
				slot = i;
		end
		case (op)
			CMD_ADD, CMD_MODIFY: begin
				if (id == '0 || px == '0 || qty == '0) begin
					res.status = ST_INVALID;
				end else if (op == CMD_MODIFY) begin
					if (hit < 0) begin
						res.status = ST_NOT_FOUND;
					end else begin
						slot_px[hit] = px;
						slot_qty[hit] = qty;
					end
				end else begin
					if (hit >= 0)
						slot = hit;
					if (slot < 0) begin
						res.status = ST_FULL;
					end else begin
						slot_used[slot] = 1'b1;
						slot_key[slot] = id;
						slot_px[slot] = px;
						slot_qty[slot] = qty;
						slot_side[slot] = side;
					end
				end
			end
			CMD_DELETE: begin
				if (id == '0)
					res.status = ST_INVALID;
				else if (hit < 0)
					res.status = ST_NOT_FOUND;
				else
					slot_used[hit] = 1'b0;
			end
			default: begin
				if (id == '0 || hit < 0) begin
					res.status = ST_NOT_FOUND;
				end else begin
					res.px = slot_px[hit];
					res.qty = slot_qty[hit];
					res.side = slot_side[hit];
				end
			end
		endcase
		return res;
	endfunction

	function automatic order_req_t order_row(cmd_t op, logic [31:0] id, logic [31:0] px,
		logic [30:0] qty, logic side, bit fixed = 1'b0, status_t st = ST_OK,
		logic [31:0] want_px = '0, logic [30:0] want_qty = '0, logic want_side = 1'b0);
		order_req_t r;
		r.op = op;
		r.id = id;
		r.px = px;
		r.qty = qty;
		r.side = side;
		r.fixed = fixed;
		r.want.status = st;
		r.want.px = want_px;
		r.want.qty = want_qty;
		r.want.side = want_side;
		return r;
	endfunction

	function automatic order_req_t random_req(traffic_t kind);
		order_req_t r;
		r.fixed = 1'b0;
		r.want = '0;
		r.px = $urandom;
		r.qty = 31'($urandom);
		r.side = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 15) == 0)
			r.px = 32'hFFFF_FFFF;
		if ($urandom_range(0, 15) == 0)
			r.qty = 31'h7FFF_FFFF;
		if (r.px == '0)
			r.px = 32'd1;
		if (r.qty == '0)
			r.qty = 31'd1;
		case (kind)
			MIX_FILL: begin
				r.op = ($urandom_range(0, 9) == 0) ? CMD_GET : CMD_ADD;
				r.id = id_pool[pool_walk % POOL_SIZE];
				pool_walk++;
			end
			MIX_DRAIN: begin
				r.op = ($urandom_range(0, 4) == 0) ? CMD_GET : CMD_DELETE;
				r.id = id_pool[pool_walk % POOL_SIZE];
				pool_walk++;
			end
			MIX_CHURN: begin
				r.op = cmd_t'($urandom_range(0, 3));
				r.id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
			end
			default: begin
				r.op = cmd_t'($urandom_range(0, 3));
				case ($urandom_range(0, 3))
					0: r.id = '0;
					1: r.id = $urandom;
					2: r.id = 32'hFFFF_FFFF;
					default: r.id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
				endcase
				if ($urandom_range(0, 3) == 0)
					r.px = '0;
				if ($urandom_range(0, 3) == 0)
					r.qty = '0;
			end
		endcase
		return r;
	endfunction

	task automatic send_req(input order_req_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		in_valid <= 1'b1;
		cmd <= r.op;
		order_id <= r.id;
		price <= r.px;
		quantity <= r.qty;
		is_buy <= r.side;
		req_fixed <= r.fixed;
		req_want <= r.want;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	function automatic void report_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : book_monitor
		book_result_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				want = apply_order_cmd(cmd_t'(cmd), order_id, price, quantity, is_buy);
				if (req_fixed)
					want = req_want;
				book_results_due.push_back(want);
				reqs_taken++;
			end
			if (out_valid && !out_stall) begin
				if (book_results_due.size() == 0) begin
					errors++;
					$display("%0t: result with status %0h arrived with no request waiting",
						$time, status);
				end else begin
					want = book_results_due.pop_front();
					report_field("status", 32'(want.status), 32'(status));
					report_field("entry_price", want.px, entry_price);
					report_field("entry_quantity", 32'(want.qty), 32'(entry_quantity));
					report_field("entry_is_buy", 32'(want.side), 32'(entry_is_buy));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// The receiver holds off once for a long stretch so that the queue fills and stalls requests.
	initial begin : receiver
		rx_mode_t mode;
		int mode_left;
		int hold_left;
		int tick;
		bit held;
		logic stall_next;
		mode = RX_FREE;
		mode_left = 0;
		hold_left = 0;
		tick = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			tick++;
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else if (!held && reqs_taken >= 300) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
				stall_next = 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					RX_FREE: stall_next = 1'b0;
					RX_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
					RX_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
					default: stall_next = (tick % 7 >= 4);
				endcase
			end
			out_stall <= stall_next;
		end
	end

	initial begin : sender
		traffic_t kind;
		int phase_len;
		int random_left;
		bit fresh;
		slot_used = '{default: 1'b0};
		for (int i = 0; i < POOL_SIZE; i++) begin
			do begin
				id_pool[i] = $urandom;
				fresh = (id_pool[i] != '0);
				for (int j = 0; j < i; j++)
					if (id_pool[j] == id_pool[i])
						fresh = 1'b0;
			end while (!fresh);
		end
		directed_rows = '{
			order_row(CMD_GET, 32'd5, 32'd10, 31'd10, 1'b0, 1'b1, ST_NOT_FOUND),
			order_row(CMD_ADD, 32'd0, 32'd10, 31'd10, 1'b1, 1'b1, ST_INVALID),
			order_row(CMD_ADD, 32'd7, 32'd0, 31'd10, 1'b1, 1'b1, ST_INVALID),
			order_row(CMD_ADD, 32'd7, 32'd10, 31'd0, 1'b0, 1'b1, ST_INVALID),
			order_row(CMD_MODIFY, 32'd0, 32'd10, 31'd10, 1'b0, 1'b1, ST_INVALID),
			order_row(CMD_DELETE, 32'd0, 32'd0, 31'd0, 1'b0, 1'b1, ST_INVALID),
			order_row(CMD_GET, 32'd0, 32'd0, 31'd0, 1'b0, 1'b1, ST_NOT_FOUND),
			order_row(CMD_MODIFY, 32'd9, 32'd10, 31'd10, 1'b0, 1'b1, ST_NOT_FOUND),
			order_row(CMD_DELETE, 32'd9, 32'd0, 31'd0, 1'b0, 1'b1, ST_NOT_FOUND),
			order_row(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 1'b1, ST_OK),
			order_row(CMD_GET, 32'hFFFF_FFFF, 32'd0, 31'd0, 1'b0, 1'b1, ST_OK,
				32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1),
			order_row(CMD_ADD, 32'd1, 32'd1, 31'd1, 1'b0, 1'b1, ST_OK),
			order_row(CMD_GET, 32'd1, 32'd0, 31'd0, 1'b1, 1'b1, ST_OK, 32'd1, 31'd1, 1'b0),
			order_row(CMD_ADD, 32'd1, 32'd77, 31'd88, 1'b1),
			order_row(CMD_GET, 32'd1, 32'd0, 31'd0, 1'b0),
			order_row(CMD_MODIFY, 32'd1, 32'd5, 31'd6, 1'b0),
			order_row(CMD_GET, 32'd1, 32'd0, 31'd0, 1'b0),
			order_row(CMD_MODIFY, 32'd1, 32'd0, 31'd6, 1'b1, 1'b1, ST_INVALID),
			order_row(CMD_MODIFY, 32'hFFFF_FFFF, 32'd3, 31'd0, 1'b0, 1'b1, ST_INVALID),
			order_row(CMD_DELETE, 32'd1, 32'd0, 31'd0, 1'b0, 1'b1, ST_OK),
			order_row(CMD_GET, 32'd1, 32'd0, 31'd0, 1'b0, 1'b1, ST_NOT_FOUND),
			order_row(CMD_DELETE, 32'd1, 32'd0, 31'd0, 1'b0, 1'b1, ST_NOT_FOUND),
			order_row(CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1),
			order_row(CMD_ADD, 32'h8000_0000, 32'h8000_0000, 31'h4000_0000, 1'b1),
			order_row(CMD_GET, 32'h8000_0000, 32'd0, 31'd0, 1'b0)
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_req(directed_rows[i]);
		// The first phase adds more distinct orders than the table holds, so it runs into full.
		kind = MIX_FILL;
		phase_len = 90;
		random_left = RANDOM_REQS;
		while (random_left > 0) begin
			for (int n = 0; n < phase_len && random_left > 0; n++) begin
				send_req(random_req(kind));
				random_left--;
			end
			kind = traffic_t'($urandom_range(0, 3));
			phase_len = $urandom_range(40, 160);
		end
		in_valid <= 1'b0;
		while (book_results_due.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 16) @(posedge clk);
		if (errors == 0 && book_results_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
